/* rtl/mwo_pkg.sv */
// Package of the multi-waveform oscillator: codes, command and status structs,
// and the quarter-wave sine table worked out at elaboration.
// Depends on nothing; the datapath, controller, top level and bench import it.
package mwo_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_DUTY     = 2'd3;

    localparam logic [2:0] SHAPE_SQUARE   = 3'd0;
    localparam logic [2:0] SHAPE_SAW      = 3'd1;
    localparam logic [2:0] SHAPE_PULSE    = 3'd2;
    localparam logic [2:0] SHAPE_SINE     = 3'd3;
    localparam logic [2:0] SHAPE_TRIANGLE = 3'd4;
    localparam logic [2:0] SHAPE_INV_TRI  = 3'd5;
    localparam logic [2:0] SHAPE_DBL_SAW  = 3'd6;
    localparam logic [2:0] SHAPE_SILENCE  = 3'd7;

    // How the sample of one word is formed.
    localparam logic [1:0] KIND_CONST = 2'd0;
    localparam logic [1:0] KIND_RAMP  = 2'd1;
    localparam logic [1:0] KIND_SINE  = 2'd2;

    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_IDX_W         = 8;
    localparam int SINE_ENTRY_W       = 17;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SERIES_DIV [1:5] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110};

    typedef logic [SINE_ENTRY_W-1:0] sine_tab_t [0:SINE_TABLE_ENTRIES];

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_phase;
        logic load_slope;
        logic load_phase;
        logic step1;
        logic step2;
        logic step3;
        logic step4;
        logic out_load;
    } mwo_cmd_t;

    typedef struct packed {
        logic recalc_pending;
        logic div_done;
        logic out_free;
    } mwo_stat_t;

    // Odd power series of sin over the first quarter, in Q30, rounded to Q1.15.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint s;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++)
        begin
            x    = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 5; n++)
            begin
                term = ((term * x2) >> 30) / SERIES_DIV[n];
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            s = (sum + 16384) / 32768;
            if (s > 32768)
                s = 32768;
            tab[i] = SINE_ENTRY_W'(s);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* rtl/mwo_ifs.sv */
// Handshake channels of the oscillator: configuration writes, requests, samples.
// Uses no package; each carries valid, ready and its payload.
interface osc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface osc_req_if;
    logic valid;
    logic ready;
    logic tick;
    logic restart;
    modport source (output valid, tick, restart, input ready);
    modport sink   (input valid, tick, restart, output ready);
endinterface

interface osc_rsp_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
    modport source (output valid, sample, clipped, input ready);
    modport sink   (input valid, sample, clipped, output ready);
endinterface

/* rtl/mwo_div.sv */
// Restoring divider, one quotient bit per cycle, for the slope and phase step.
// Uses no package.
module mwo_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [32:0] quotient
);

    localparam int DVD_W = 33;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [32:0] quo_reg;
    logic [15:0] dvs_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 16'(trial - {1'b0, dvs_reg}) : trial[15:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/mwo_dp.sv */
// Datapath of the oscillator: registers, position state, slope division,
// ramp and sine arithmetic over five steps, and the output register.
// Depends on mwo_pkg and mwo_div.
module mwo_dp #(
    parameter int POSITION_BITS = 16,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mwo_pkg::mwo_cmd_t             cmd,
    output mwo_pkg::mwo_stat_t            stat,
    input  logic                          cfg_write,
    input  logic [mwo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_restart,
    input  logic                          out_accept,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_clipped
);

    import mwo_pkg::*;

    localparam int PB       = POSITION_BITS;
    localparam int CMP_W    = ((PB > 16) ? PB : 16) + 2;
    localparam int RPROD_W  = 32 + PB;
    localparam int S_W      = RPROD_W - 16;
    localparam int V_W      = S_W + 4;
    localparam int SHIFT_UP = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
    localparam int SHIFT_DN = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam int X_W      = V_W + SHIFT_UP;

    localparam logic signed [X_W-1:0] DN_BIAS = X_W'((64'd1 << SHIFT_DN) - 64'd1);
    localparam logic signed [X_W-1:0] SAT_HI  = X_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [X_W-1:0] SAT_LO  = ~SAT_HI;

    // Configuration.
    logic [2:0]  wave_reg;
    logic [15:0] period_reg;
    logic [14:0] amp_reg;
    logic [15:0] duty_reg;
    logic        pending_reg;
    logic [15:0] eff_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg    <= SHAPE_SQUARE;
            period_reg  <= 16'd100;
            amp_reg     <= '0;
            duty_reg    <= '0;
            pending_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            pending_reg <= 1'b1;
            unique case (cfg_index)
                REG_WAVE_SELECT:    wave_reg   <= cfg_data[2:0];
                REG_PERIOD_SAMPLES: period_reg <= cfg_data;
                REG_AMPLITUDE:      amp_reg    <= cfg_data[14:0];
                REG_PULSE_DUTY:     duty_reg   <= cfg_data;
                default:            ;
            endcase
        end
        else if (cmd.div_start && !cmd.div_phase)
        begin
            pending_reg <= 1'b0;
        end
    end

    assign eff_p = (period_reg < 16'd2) ? 16'd2 : period_reg;

    // Slope and phase step.
    logic [32:0] div_dividend;
    logic [32:0] div_quo;
    logic        div_done;
    logic [31:0] slope_reg;
    logic [23:0] pstep_reg;

    always_comb
    begin
        if (cmd.div_phase)
            div_dividend = (33'd1 << 24) + {17'b0, 1'b0, eff_p[15:1]};
        else if (wave_reg == SHAPE_SAW)
            div_dividend = {1'b0, amp_reg, 17'b0};
        else
            div_dividend = {amp_reg, 18'b0};
    end

    mwo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (eff_p),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg <= '0;
            pstep_reg <= '0;
        end
        else
        begin
            if (cmd.load_slope)
                slope_reg <= div_quo[31:0];
            if (cmd.load_phase)
                pstep_reg <= div_quo[23:0];
        end
    end

    // Step one: next position and segment, and how the sample is formed.
    logic          restart_reg;
    logic [PB-1:0] position_reg;
    logic [1:0]    segment_reg;
    logic [PB-1:0] pos_n;
    logic [PB-1:0] pos_adv;
    logic [PB-1:0] pos_wrap;
    logic [PB-1:0] pos_pulse;
    logic [1:0]    seg_n;
    logic [1:0]    kind_n;
    logic          sneg_n;
    logic signed [3:0] amul_n;
    logic [CMP_W-1:0]  qx;
    logic [CMP_W-1:0]  px;
    logic          ge_full;
    logic          ge_half;
    logic          ge_q1;
    logic          ge_q3;
    logic          is_inv;

    assign qx       = CMP_W'(position_reg);
    assign px       = CMP_W'(eff_p);
    assign ge_full  = qx >= px;
    assign ge_half  = (qx << 1) >= px;
    assign ge_q1    = (qx << 2) >= px;
    assign ge_q3    = (qx << 2) >= (px + (px << 1));
    assign pos_adv  = position_reg + 1'b1;
    assign pos_wrap = position_reg - px[PB-1:0];
    assign pos_pulse = ge_full ? '0 : pos_adv;
    assign is_inv   = wave_reg == SHAPE_INV_TRI;

    always_comb
    begin
        pos_n  = position_reg;
        seg_n  = segment_reg;
        kind_n = KIND_CONST;
        sneg_n = 1'b0;
        amul_n = 4'sd0;
        if (restart_reg)
        begin
            pos_n = '0;
            seg_n = 2'd0;
        end
        else
        begin
            unique case (wave_reg)
                SHAPE_SQUARE:
                begin
                    if (ge_half)
                    begin
                        amul_n = 4'sd1;
                        pos_n  = ge_full ? pos_wrap : pos_adv;
                    end
                    else
                    begin
                        amul_n = -4'sd1;
                        pos_n  = pos_adv;
                    end
                end
                SHAPE_SAW:
                begin
                    kind_n = KIND_RAMP;
                    if (segment_reg == 2'd0)
                    begin
                        pos_n = pos_adv;
                        if (ge_half)
                        begin
                            seg_n  = 2'd1;
                            amul_n = -4'sd2;
                        end
                    end
                    else
                    begin
                        amul_n = -4'sd2;
                        pos_n  = ge_full ? pos_wrap : pos_adv;
                        if (ge_full)
                            seg_n = 2'd0;
                    end
                end
                SHAPE_PULSE:
                begin
                    pos_n  = pos_pulse;
                    amul_n = (CMP_W'(pos_pulse) >= CMP_W'(duty_reg)) ? 4'sd1 : -4'sd1;
                end
                SHAPE_SINE:
                begin
                    kind_n = KIND_SINE;
                    pos_n  = ge_full ? pos_wrap : pos_adv;
                end
                SHAPE_TRIANGLE:
                begin
                    kind_n = KIND_RAMP;
                    if (segment_reg == 2'd0)
                    begin
                        pos_n = pos_adv;
                        if (ge_q1)
                        begin
                            seg_n  = 2'd1;
                            sneg_n = 1'b1;
                            amul_n = 4'sd2;
                        end
                    end
                    else if (segment_reg == 2'd1)
                    begin
                        pos_n = pos_adv;
                        if (ge_q3)
                        begin
                            seg_n  = 2'd2;
                            amul_n = -4'sd4;
                        end
                        else
                        begin
                            sneg_n = 1'b1;
                            amul_n = 4'sd2;
                        end
                    end
                    else
                    begin
                        amul_n = -4'sd4;
                        pos_n  = ge_full ? pos_wrap : pos_adv;
                        if (ge_full)
                            seg_n = 2'd0;
                    end
                end
                SHAPE_INV_TRI, SHAPE_DBL_SAW:
                begin
                    kind_n = KIND_RAMP;
                    if (segment_reg == 2'd0)
                    begin
                        pos_n = pos_adv;
                        if (ge_q1)
                        begin
                            seg_n  = 2'd1;
                            amul_n = -4'sd1;
                        end
                        else
                        begin
                            sneg_n = 1'b1;
                            amul_n = 4'sd1;
                        end
                    end
                    else if (segment_reg == 2'd1)
                    begin
                        pos_n = pos_adv;
                        if (ge_half)
                            seg_n = 2'd2;
                        if (is_inv)
                            amul_n = ge_half ? -4'sd3 : -4'sd1;
                        else
                            amul_n = -4'sd2;
                    end
                    else if (segment_reg == 2'd2)
                    begin
                        pos_n = pos_adv;
                        if (ge_q3)
                        begin
                            seg_n  = 2'd3;
                            sneg_n = 1'b1;
                            amul_n = 4'sd3;
                        end
                        else
                        begin
                            amul_n = is_inv ? -4'sd3 : -4'sd2;
                        end
                    end
                    else
                    begin
                        sneg_n = 1'b1;
                        amul_n = 4'sd3;
                        pos_n  = ge_full ? pos_wrap : pos_adv;
                        if (ge_full)
                            seg_n = 2'd0;
                    end
                end
                SHAPE_SILENCE:
                begin
                    pos_n = '0;
                end
                default: ;
            endcase
        end
    end

    logic [1:0]         kind_reg;
    logic               sneg_reg;
    logic signed [3:0]  amul_reg;
    logic [RPROD_W-1:0] rprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            segment_reg  <= 2'd0;
        end
        else if (cmd.step1)
        begin
            position_reg <= pos_n;
            segment_reg  <= seg_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            restart_reg <= in_restart;
        if (cmd.step1)
        begin
            kind_reg  <= kind_n;
            sneg_reg  <= sneg_n;
            amul_reg  <= amul_n;
            rprod_reg <= RPROD_W'(slope_reg) * RPROD_W'(position_reg);
        end
    end

    // Step two: rounded ramp term and the sine phase of the new position.
    logic [S_W-1:0] s_reg;
    logic [23:0]    phase_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.step2)
        begin
            s_reg     <= S_W'((rprod_reg + RPROD_W'(16'h8000)) >> 16);
            phase_reg <= 24'(position_reg * pstep_reg);
        end
    end

    // Step three: piecewise ramp value and the table read.
    logic signed [V_W-1:0]   a_x;
    logic signed [V_W-1:0]   s_x;
    logic signed [V_W-1:0]   aterm;
    logic signed [V_W-1:0]   rterm;
    logic signed [V_W-1:0]   v_reg;
    logic [SINE_IDX_W-1:0]   sidx;
    logic [SINE_IDX_W:0]     tab_idx;
    logic [SINE_ENTRY_W-1:0] entry_reg;
    logic [1:0]              quad_reg;

    assign a_x = $signed(V_W'(amp_reg));
    assign s_x = $signed({4'b0, s_reg});

    always_comb
    begin
        unique case (amul_reg)
            4'sd1:   aterm = a_x;
            4'sd2:   aterm = a_x <<< 1;
            4'sd3:   aterm = a_x + (a_x <<< 1);
            -4'sd1:  aterm = -a_x;
            -4'sd2:  aterm = -(a_x <<< 1);
            -4'sd3:  aterm = -(a_x + (a_x <<< 1));
            -4'sd4:  aterm = -(a_x <<< 2);
            default: aterm = '0;
        endcase
        if (kind_reg == KIND_RAMP)
            rterm = sneg_reg ? -s_x : s_x;
        else
            rterm = '0;
    end

    assign sidx    = phase_reg[21 -: SINE_IDX_W];
    assign tab_idx = phase_reg[22] ? (SINE_IDX_W + 1)'(SINE_TABLE_ENTRIES) - {1'b0, sidx}
                                   : {1'b0, sidx};

    always_ff @(posedge clk)
    begin
        if (cmd.step3)
        begin
            v_reg     <= rterm + aterm;
            entry_reg <= SINE_TAB[tab_idx];
            quad_reg  <= phase_reg[23:22];
        end
    end

    // Step four: amplitude times table entry.
    logic [31:0] sprod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.step4)
            sprod_reg <= 32'(amp_reg) * 32'(entry_reg);
    end

    // Step five: sign, width scaling and saturation into the output register.
    logic [16:0]           mag;
    logic signed [V_W-1:0] sine_v;
    logic signed [V_W-1:0] vsel;
    logic signed [X_W-1:0] vx;
    logic signed [X_W-1:0] scaled;
    logic                  sat_hi;
    logic                  sat_lo;
    logic                  out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                  clip_reg;

    assign mag    = 17'((sprod_reg + 32'd16384) >> 15);
    assign sine_v = quad_reg[1] ? -$signed(V_W'(mag)) : $signed(V_W'(mag));
    assign vsel   = (kind_reg == KIND_SINE) ? sine_v : v_reg;
    assign vx     = X_W'(vsel);
    assign scaled = ($signed(vx + (vx[X_W-1] ? DN_BIAS : '0)) >>> SHIFT_DN) <<< SHIFT_UP;
    assign sat_hi = scaled > SAT_HI;
    assign sat_lo = scaled < SAT_LO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_accept)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (sat_hi)
                sample_reg <= SAT_HI[SAMPLE_BITS-1:0];
            else if (sat_lo)
                sample_reg <= SAT_LO[SAMPLE_BITS-1:0];
            else
                sample_reg <= scaled[SAMPLE_BITS-1:0];
            clip_reg <= sat_hi | sat_lo;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sample  = sample_reg;
    assign out_clipped = clip_reg;

    assign stat.recalc_pending = pending_reg;
    assign stat.div_done       = div_done;
    assign stat.out_free       = !out_valid_reg || out_accept;

endmodule

/* rtl/mwo_ctrl.sv */
// Controller of the oscillator: recomputes slope and phase step after a write,
// then steps one request at a time through the datapath.
// Depends on mwo_pkg.
module mwo_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_active,
    input  mwo_pkg::mwo_stat_t stat,
    output logic               in_ready,
    output mwo_pkg::mwo_cmd_t  cmd
);

    import mwo_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIVS   = 4'd1;
    localparam logic [3:0] ST_DIVP   = 4'd2;
    localparam logic [3:0] ST_STEP1  = 4'd3;
    localparam logic [3:0] ST_STEP2  = 4'd4;
    localparam logic [3:0] ST_STEP3  = 4'd5;
    localparam logic [3:0] ST_STEP4  = 4'd6;
    localparam logic [3:0] ST_OUTPUT = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE) && !stat.recalc_pending;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                priority if (stat.recalc_pending)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVS;
                end
                else if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (in_active)
                        state_next = ST_STEP1;
                end
            end
            ST_DIVS:
            begin
                if (stat.div_done)
                begin
                    cmd.load_slope = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_phase  = 1'b1;
                    state_next     = ST_DIVP;
                end
            end
            ST_DIVP:
            begin
                cmd.div_phase = 1'b1;
                if (stat.div_done)
                begin
                    cmd.load_phase = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_STEP1:
            begin
                cmd.step1  = 1'b1;
                state_next = ST_STEP2;
            end
            ST_STEP2:
            begin
                cmd.step2  = 1'b1;
                state_next = ST_STEP3;
            end
            ST_STEP3:
            begin
                cmd.step3  = 1'b1;
                state_next = ST_STEP4;
            end
            ST_STEP4:
            begin
                cmd.step4  = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/multi_waveform_oscillator_top.sv */
// Top level of the single-voice waveform oscillator.
// Depends on mwo_pkg, the channel interfaces, mwo_ctrl and mwo_dp.
//
// Use of the block:
//   cfg  - write channel; index 0 wave select, 1 period in samples, 2 amplitude
//          (Q0.15), 3 pulse duty. It is always ready. Every write flags a
//          recomputation of the ramp slope and the sine phase step, run on a shared
//          one-bit-per-cycle divider once the controller is idle: slope, then phase
//          step, so req is held not ready after the write until both are loaded.
//   req  - one word per sample request, carrying tick and restart. A word with
//          neither bit set is taken and yields no sample.
//   rsp  - one word per request with tick or restart: a signed Q1.15 sample
//          (rescaled for other widths) and a flag that saturation occurred.
// Steps: a request passes five controller steps (state
// update with the ramp multiply, rounding with the phase multiply, table read,
// amplitude multiply, saturation) before its word is loaded into the output
// register; the controller steps one request at a time, so it takes no new
// request until the last one has left its last step.
// Reset runs the slope and phase step recomputation with the reset register
// values before the first request is accepted. When the receiver stalls, the
// finished word waits in the output register while the next request is
// accepted and worked on; it then waits in its last step until the register
// frees.
module multi_waveform_oscillator_top #(
    parameter int POSITION_BITS = 16,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    osc_cfg_if.sink    cfg,
    osc_req_if.sink    req,
    osc_rsp_if.source  rsp
);

    import mwo_pkg::*;

    mwo_cmd_t  cmd;
    mwo_stat_t stat;
    logic      in_ready;

    // Configuration is always taken; the datapath flags the recomputation.
    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;

    mwo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_active (req.tick | req.restart),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    mwo_dp #(
        .POSITION_BITS (POSITION_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_write   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .in_restart  (req.restart),
        .out_accept  (rsp.valid & rsp.ready),
        .out_valid   (rsp.valid),
        .out_sample  (rsp.sample),
        .out_clipped (rsp.clipped)
    );

endmodule

/* rtl/mwo_checker.sv */
// Port-level checks of the oscillator and their binding to the top level.
// Depends on multi_waveform_oscillator_top.
module mwo_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic signed [SAMPLE_BITS-1:0] rsp_sample,
    input logic                          rsp_clipped
);

    localparam logic signed [SAMPLE_BITS-1:0] MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A stalled word keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_clipped))
        else $error("stalled sample word changed");

    // After a configuration write, req is not ready; the check does not follow the recomputation to its end.
    a_recalc: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !req_ready)
        else $error("request taken during recomputation");

    // A saturated word sits at one end of the range.
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_clipped |-> rsp_sample == MAX_S || rsp_sample == MIN_S)
        else $error("clipped sample not at a range limit");

endmodule

bind multi_waveform_oscillator_top mwo_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mwo_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_sample  (rsp.sample),
    .rsp_clipped (rsp.clipped)
);

/* tb/tb_ifs_note.sv */
`timescale 1ns / 100ps
// Shared testbench types for the oscillator bench: the expected-sample record
// and the request record. Depends on nothing; the bench top imports it.
package osc_tb_pkg;
    typedef struct packed {
        logic signed [15:0] sample;
        logic               clipped;
    } osc_sample_t;

    typedef struct packed {
        logic tick;
        logic restart;
    } osc_request_t;
endpackage

/* tb/tb.sv */
`timescale 1ns / 100ps
// Bench top for the multi-waveform oscillator: drives requests and register writes,
// predicts every sample and compares the returned words. Depends on mwo_pkg,
// osc_tb_pkg, the channel interfaces and multi_waveform_oscillator_top.
module tb;
    import mwo_pkg::*;
    import osc_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RECALC_CYCLES  = 80;

    logic clk;
    logic rst_n;

    osc_cfg_if cfg ();
    osc_req_if req ();
    osc_rsp_if #(.SAMPLE_BITS(16)) rsp ();

    multi_waveform_oscillator_top #(
        .POSITION_BITS(16),
        .SAMPLE_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .req(req),
        .rsp(rsp)
    );

    // Predictor state: registers, derived terms and the running position.
    logic [2:0]  osc_wave;
    logic [15:0] osc_period;
    logic [14:0] osc_amp;
    logic [15:0] osc_duty;
    logic [15:0] osc_pos;
    logic [1:0]  osc_seg;
    logic [31:0] osc_slope;
    logic [23:0] osc_phase_step;
    int unsigned sine_rom [0:256];

    osc_request_t request_queue [$];
    osc_sample_t  expected_samples [$];

    int  fail_count;
    int  idle_cycles;
    int  sample_count;
    bit  allow_idle;
    int  src_gap;
    int  snk_gap;

    // The clock simply toggles every half period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // The table is rebuilt from the same power series, in the bench's own terms.
    function automatic void fill_sine_rom();
        longint unsigned x, x2, term;
        longint sum, s;
        for (int i = 0; i <= 256; i++)
        begin
            x    = (longint'(i) * 64'd1686629713) / 256;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 5; n++)
            begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            s = (sum + 16384) / 32768;
            if (s > 32768)
                s = 32768;
            sine_rom[i] = int'(s);
        end
    endfunction

    function automatic longint unsigned period_in_use();
        return (osc_period < 16'd2) ? 64'd2 : 64'(osc_period);
    endfunction

    // Slope and phase step follow every register write.
    function automatic void derive_terms();
        longint unsigned p, k;
        p = period_in_use();
        k = (osc_wave == SHAPE_SAW) ? 64'd2 : 64'd4;
        osc_slope      = 32'(((k * 64'(osc_amp)) << 16) / p);
        osc_phase_step = 24'(((64'd1 << 24) + p / 2) / p);
    endfunction

    function automatic void apply_register(logic [1:0] idx, logic [15:0] val);
        case (idx)
            REG_WAVE_SELECT:    osc_wave   = val[2:0];
            REG_PERIOD_SAMPLES: osc_period = val;
            REG_AMPLITUDE:      osc_amp    = val[14:0];
            default:            osc_duty   = val;
        endcase
        derive_terms();
    endfunction

    function automatic void step_position();
        osc_pos = osc_pos + 16'd1;
    endfunction

    function automatic void wrap_or_step();
        longint unsigned p;
        p = period_in_use();
        if (64'(osc_pos) >= p)
        begin
            osc_pos = osc_pos - 16'(p);
            osc_seg = 2'd0;
        end
        else
            step_position();
    endfunction

    function automatic longint sine_level();
        logic [23:0] ph;
        logic [1:0]  quad;
        int unsigned idx, e;
        longint      mag;
        ph   = 24'(64'(osc_pos) * 64'(osc_phase_step));
        quad = ph[23:22];
        idx  = int'((64'(ph[21:0]) * 256) >> 22);
        e    = quad[0] ? sine_rom[256 - idx] : sine_rom[idx];
        mag  = longint'((64'(osc_amp) * e + 16384) >> 15);
        return quad[1] ? -mag : mag;
    endfunction

    // Works out the next waveform value and advances position and segment.
    function automatic longint next_level();
        longint unsigned p, q;
        longint a, s, v;
        p = period_in_use();
        q = 64'(osc_pos);
        a = longint'(osc_amp);
        s = longint'((64'(osc_slope) * q + 64'h8000) >> 16);
        v = 0;
        case (osc_wave)
            SHAPE_SQUARE:
            begin
                if (2 * q >= p)
                begin
                    v = a;
                    if (q >= p) osc_pos = osc_pos - 16'(p); else step_position();
                end
                else
                begin
                    step_position();
                    v = -a;
                end
            end
            SHAPE_SAW:
            begin
                if (osc_seg == 2'd0)
                begin
                    if (2 * q >= p) begin osc_seg = 2'd1; v = s - 2 * a; end
                    else v = s;
                    step_position();
                end
                else
                begin
                    v = s - 2 * a;
                    wrap_or_step();
                end
            end
            SHAPE_PULSE:
            begin
                if (q >= p) osc_pos = 16'd0; else step_position();
                v = (osc_pos >= osc_duty) ? a : -a;
            end
            SHAPE_SINE:
            begin
                if (q >= p) osc_pos = osc_pos - 16'(p); else step_position();
                v = sine_level();
            end
            SHAPE_TRIANGLE:
            begin
                if (osc_seg == 2'd0)
                begin
                    if (4 * q >= p) begin osc_seg = 2'd1; v = 2 * a - s; end
                    else v = s;
                    step_position();
                end
                else if (osc_seg == 2'd1)
                begin
                    if (4 * q >= 3 * p) begin osc_seg = 2'd2; v = s - 4 * a; end
                    else v = 2 * a - s;
                    step_position();
                end
                else
                begin
                    v = s - 4 * a;
                    wrap_or_step();
                end
            end
            SHAPE_INV_TRI, SHAPE_DBL_SAW:
            begin
                if (osc_seg == 2'd0)
                begin
                    if (4 * q >= p) begin osc_seg = 2'd1; v = s - a; end
                    else v = a - s;
                    step_position();
                end
                else if (osc_seg == 2'd1)
                begin
                    if (osc_wave == SHAPE_INV_TRI)
                    begin
                        if (2 * q >= p) begin osc_seg = 2'd2; v = s - 3 * a; end
                        else v = s - a;
                    end
                    else
                    begin
                        if (2 * q >= p) osc_seg = 2'd2;
                        v = s - 2 * a;
                    end
                    step_position();
                end
                else if (osc_seg == 2'd2)
                begin
                    if (4 * q >= 3 * p) begin osc_seg = 2'd3; v = 3 * a - s; end
                    else v = (osc_wave == SHAPE_INV_TRI) ? s - 3 * a : s - 2 * a;
                    step_position();
                end
                else
                begin
                    v = 3 * a - s;
                    wrap_or_step();
                end
            end
            default:
            begin
                osc_pos = 16'd0;
                v = 0;
            end
        endcase
        return v;
    endfunction

    // Turns one accepted request into its expected word, if it yields one.
    function automatic void predict_request(osc_request_t r);
        osc_sample_t exp_word;
        longint v;
        if (r.restart)
        begin
            osc_pos = 16'd0;
            osc_seg = 2'd0;
            exp_word.sample  = 16'sd0;
            exp_word.clipped = 1'b0;
            expected_samples.push_back(exp_word);
        end
        else if (r.tick)
        begin
            v = next_level();
            exp_word.clipped = 1'b0;
            if (v > 32767) begin v = 32767; exp_word.clipped = 1'b1; end
            if (v < -32768) begin v = -32768; exp_word.clipped = 1'b1; end
            exp_word.sample = 16'(v);
            expected_samples.push_back(exp_word);
        end
    endfunction

    // Request driver: holds valid until the word is taken, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.tick    <= 1'b0;
            req.restart <= 1'b0;
            src_gap     <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_request('{tick: req.tick, restart: req.restart});
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                if (req.valid && req.ready)
                    req.valid <= 1'b0;
            end
            else if (!req.valid || req.ready)
            begin
                if (allow_idle && $urandom_range(0, 5) == 0)
                begin
                    src_gap   <= $urandom_range(1, 6);
                    req.valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    req.valid   <= 1'b1;
                    req.tick    <= request_queue[0].tick;
                    req.restart <= request_queue[0].restart;
                    void'(request_queue.pop_front());
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Sample monitor: random back-pressure and a comparison with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            snk_gap   <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                sample_count <= sample_count + 1;
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual sample %0d clipped %0b",
                             $time, rsp.sample, rsp.clipped);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (rsp.sample !== expected_samples[0].sample
                        || rsp.clipped !== expected_samples[0].clipped)
                    begin
                        $display("%0t: mismatch, expected sample %0d clipped %0b, actual sample %0d clipped %0b",
                                 $time, expected_samples[0].sample, expected_samples[0].clipped,
                                 rsp.sample, rsp.clipped);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_samples.pop_front());
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap   <= snk_gap - 1;
                rsp.ready <= (snk_gap == 1);
            end
            else if (allow_idle && $urandom_range(0, 5) == 0)
            begin
                snk_gap   <= $urandom_range(1, 6);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which no channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[multi_waveform_oscillator_top] ERROR");
            $finish;
        end
    end

    // Waits until every queued request is taken and every expected word has arrived,
    // then lets the block's own pipeline settle.
    task automatic drain_block();
        while (request_queue.size() > 0 || req.valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A register write is only issued while the block is idle.
    task automatic write_register(logic [1:0] idx, logic [15:0] val);
        drain_block();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        apply_register(idx, val);
        cfg.valid <= 1'b0;
        repeat (RECALC_CYCLES) @(posedge clk);
    endtask

    task automatic set_voice(logic [2:0] wave, logic [15:0] period,
                             logic [14:0] amp, logic [15:0] duty);
        write_register(REG_WAVE_SELECT, 16'(wave));
        write_register(REG_PERIOD_SAMPLES, period);
        write_register(REG_AMPLITUDE, 16'(amp));
        write_register(REG_PULSE_DUTY, duty);
    endtask

    task automatic push_request(bit tick, bit restart);
        request_queue.push_back('{tick: tick, restart: restart});
    endtask

    // Mostly ticks, with the odd restart and the odd empty word.
    task automatic push_random_run(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
                push_request(1'b0, 1'b0);
            else if (pick == 1)
                push_request($urandom_range(0, 1), 1'b1);
            else
                push_request(1'b1, 1'b0);
        end
    endtask

    initial
    begin
        logic [2:0]  wave;
        logic [15:0] period;
        logic [14:0] amp;
        int          run_len;

        rst_n        = 1'b0;
        cfg.valid    = 1'b0;
        cfg.index    = 2'd0;
        cfg.data     = 16'd0;
        fail_count   = 0;
        sample_count = 0;
        idle_cycles  = 0;
        allow_idle   = 1'b1;

        fill_sine_rom();
        osc_wave   = 3'd0;
        osc_period = 16'd100;
        osc_amp    = 15'd0;
        osc_duty   = 16'd0;
        osc_pos    = 16'd0;
        osc_seg    = 2'd0;
        derive_terms();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (RECALC_CYCLES) @(posedge clk);

        // Directed part: reset voice, an empty word, a restart winning over a tick, then saw,
        // triangle and pulse at full amplitude over tiny periods, below two too, then silence.
        push_request(1'b1, 1'b0);
        push_request(1'b0, 1'b0);
        push_request(1'b1, 1'b1);
        push_request(1'b0, 1'b1);
        drain_block();
        set_voice(SHAPE_SAW, 16'd0, 15'd32767, 16'd65535);
        for (int i = 0; i < 4; i++) push_request(1'b1, 1'b0);
        set_voice(SHAPE_TRIANGLE, 16'd1, 15'd32767, 16'd0);
        for (int i = 0; i < 4; i++) push_request(1'b1, 1'b0);
        set_voice(SHAPE_PULSE, 16'd4, 15'd32767, 16'd2);
        for (int i = 0; i < 5; i++) push_request(1'b1, 1'b0);
        write_register(REG_WAVE_SELECT, 16'(SHAPE_SILENCE));
        push_request(1'b1, 1'b0);
        push_request(1'b1, 1'b0);

        // Pause the sender on purpose until every expected word is home.
        drain_block();

        // Random part: runs of random length on random shapes, with the stale position left
        // over from the previous voice exercised on each change.
        while (request_queue.size() + sample_count < 560)
        begin
            wave   = $urandom_range(0, 7);
            period = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            amp    = ($urandom_range(0, 3) == 0) ? 15'd32767 : 15'($urandom);
            if (wave == SHAPE_SAW && $urandom_range(0, 2) == 0)
                write_register(REG_WAVE_SELECT, 16'(wave));
            else
                set_voice(wave, period, amp, 16'($urandom_range(0, 45)));
            if ($urandom_range(0, 9) == 0)
                write_register(REG_PULSE_DUTY, 16'($urandom));
            run_len = $urandom_range(10, 50);
            if (sample_count > 450)
                allow_idle = 1'b0;
            push_random_run(run_len);
            drain_block();
        end

        drain_block();
        $display("Covered all eight shapes, periods from below two to full scale, restarts");
        $display("and empty words, with random stalls on both channels; %0d words checked.",
                 sample_count);
        if (fail_count == 0 && expected_samples.size() == 0)
            $display("[multi_waveform_oscillator_top] OK");
        else
            $display("[multi_waveform_oscillator_top] ERROR");
        $finish;
    end
endmodule
